// ===== sv/tmsf_pkg.sv =====
package tmsf_pkg;

   localparam int SAMPLE_W = 12;
   localparam int CHAN_W   = 4;
   localparam int WCNT_W   = 7;

   localparam logic [WCNT_W-1:0] WCNT_RESET = 7'd10;

   // Samples dropped in total per trimmed sample: one at each end.
   localparam int TRIM_FACTOR = 2;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_LOAD = 4'b0010,
      S_DIV  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   typedef struct packed {
      logic accept;    // take the input beat into the running window
      logic load;      // start the divider and clear the window
      logic div_step;  // one quotient bit
      logic finish;    // move the quotient into the output register
   } cmd_type;

   typedef struct packed {
      logic close_now; // the beat on the input closes the window
      logic div_last;  // the divider works on its last bit
   } status_type;

endpackage

// ===== sv/trimmed_mean_sample_filter_unit.sv =====
// Trimmed-mean filter for 12-bit converter samples. Each input beat adds one
// sample to the current window; a beat that does not close the window is
// accepted without a stall. The beat that brings the window to its configured
// size (clamped to 2*TRIM+1 .. MAX_WINDOW) closes it and produces one result:
// the floor mean of the window with the TRIM smallest and TRIM largest samples
// dropped, tagged with that beat's channel. The smallest and largest samples are
// tracked as samples arrive, so closing runs through one setup state and a
// bit-serial divider before the result enters the output register; input is
// stalled during that time. A result waiting in the output register does not
// hold off input beats that do not close a window. Lowering csr_window_count
// to or below the samples already held makes the next beat close the window,
// provided that beat brings the window to at least 2*TRIM+1 samples.
module trimmed_mean_sample_filter_unit #(
   parameter int MAX_WINDOW = 64,
   parameter int TRIM       = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [tmsf_pkg::WCNT_W-1:0]   csr_window_count,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tmsf_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [tmsf_pkg::CHAN_W-1:0]   req_channel,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tmsf_pkg::SAMPLE_W-1:0] rsp_average,
   output logic [tmsf_pkg::CHAN_W-1:0]   rsp_channel_out
);

   tmsf_pkg::cmd_type    cmd;
   tmsf_pkg::status_type status;

   tmsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tmsf_datapath #(
      .MAX_WINDOW (MAX_WINDOW),
      .TRIM       (TRIM)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_window_count (csr_window_count),
      .req_sample       (req_sample),
      .req_channel      (req_channel),
      .rsp_average      (rsp_average),
      .rsp_channel_out  (rsp_channel_out),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// ===== sv/tmsf_ctrl.sv =====
module tmsf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  tmsf_pkg::status_type status,
   output tmsf_pkg::cmd_type    cmd
);

   tmsf_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != tmsf_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         tmsf_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.close_now) begin
                  state_in = tmsf_pkg::S_LOAD;
               end
            end
         end
         tmsf_pkg::S_LOAD: begin
            cmd.load = 1'b1;
            state_in = tmsf_pkg::S_DIV;
         end
         tmsf_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = tmsf_pkg::S_DONE;
            end
         end
         tmsf_pkg::S_DONE: begin
            // The previous result may still sit in the output register.
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = tmsf_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = tmsf_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tmsf_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/tmsf_datapath.sv =====
module tmsf_datapath #(
   parameter int MAX_WINDOW = 64,
   parameter int TRIM       = 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [tmsf_pkg::WCNT_W-1:0]         csr_window_count,
   input  logic [tmsf_pkg::SAMPLE_W-1:0]       req_sample,
   input  logic [tmsf_pkg::CHAN_W-1:0]         req_channel,
   output logic [tmsf_pkg::SAMPLE_W-1:0]       rsp_average,
   output logic [tmsf_pkg::CHAN_W-1:0]         rsp_channel_out,
   input  tmsf_pkg::cmd_type                   cmd,
   output tmsf_pkg::status_type                status
);

   localparam int SW     = tmsf_pkg::SAMPLE_W;
   localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W  = SW + $clog2(MAX_WINDOW);
   localparam int CMP_W  = CNT_W + tmsf_pkg::WCNT_W;
   localparam int STEP_W = $clog2(SUM_W);
   localparam int LIST_N = (TRIM > 0) ? TRIM : 1;
   // The low list starts full of top-scale entries, so its sum starts at their total.
   localparam logic [SUM_W-1:0] LO_SUM_INIT = SUM_W'(TRIM * ((1 << SW) - 1));

   logic [tmsf_pkg::WCNT_W-1:0] wcnt_ff;
   logic [CNT_W-1:0]            fill_ff, fill_in;
   logic [CNT_W-1:0]            n_ff;
   logic [CNT_W-1:0]            n_now;
   logic [SUM_W-1:0]            total_ff;
   logic [SUM_W-1:0]            lo_sum_ff, hi_sum_ff;
   logic [SUM_W-1:0]            lo_sum_in, hi_sum_in;
   logic [SW-1:0]               lo_ff [LIST_N];
   logic [SW-1:0]               hi_ff [LIST_N];
   logic [SW-1:0]               lo_in [LIST_N];
   logic [SW-1:0]               hi_in [LIST_N];
   logic [CMP_W-1:0]            n_ext, wc_ext;
   logic [SUM_W-1:0]            trimmed;
   logic [CNT_W-1:0]            kept;
   logic [SUM_W-1:0]            quo_ff, quo_in;
   logic [CNT_W-1:0]            rem_ff, rem_in;
   logic [CNT_W:0]              shifted;
   logic [CNT_W-1:0]            div_ff;
   logic [STEP_W-1:0]           step_ff;
   logic                        ge;
   logic [tmsf_pkg::CHAN_W-1:0] chan_ff;
   logic [SW-1:0]               avg_ff;
   logic [tmsf_pkg::CHAN_W-1:0] chan_out_ff;

   // Window closes when the count with this beat reaches the clamped window size.
   assign n_now  = fill_ff + CNT_W'(1);
   assign n_ext  = CMP_W'(n_now);
   assign wc_ext = CMP_W'(wcnt_ff);
   assign status.close_now = (n_ext >= CMP_W'(tmsf_pkg::TRIM_FACTOR * TRIM + 1)) &&
                             ((n_ext >= wc_ext) || (n_ext == CMP_W'(MAX_WINDOW)));
   assign fill_in = status.close_now ? '0 : n_now;

   // The TRIM smallest and TRIM largest samples are tracked as they arrive, so the
   // trimmed sum is the total minus both running extreme sums.
   generate
      if (TRIM > 0) begin : g_lists
         always_comb begin
            for (int i = 0; i < LIST_N; i++) begin
               if (req_sample < lo_ff[i]) begin
                  lo_in[i] = (i > 0 && req_sample < lo_ff[(i > 0) ? i - 1 : 0]) ?
                             lo_ff[(i > 0) ? i - 1 : 0] : req_sample;
               end else begin
                  lo_in[i] = lo_ff[i];
               end
               if (req_sample > hi_ff[i]) begin
                  hi_in[i] = (i > 0 && req_sample > hi_ff[(i > 0) ? i - 1 : 0]) ?
                             hi_ff[(i > 0) ? i - 1 : 0] : req_sample;
               end else begin
                  hi_in[i] = hi_ff[i];
               end
            end
            lo_sum_in = lo_sum_ff;
            hi_sum_in = hi_sum_ff;
            if (req_sample < lo_ff[LIST_N-1]) begin
               lo_sum_in = lo_sum_ff + SUM_W'(req_sample) - SUM_W'(lo_ff[LIST_N-1]);
            end
            if (req_sample > hi_ff[LIST_N-1]) begin
               hi_sum_in = hi_sum_ff + SUM_W'(req_sample) - SUM_W'(hi_ff[LIST_N-1]);
            end
         end
      end else begin : g_no_lists
         always_comb begin
            for (int i = 0; i < LIST_N; i++) begin
               lo_in[i] = lo_ff[i];
               hi_in[i] = hi_ff[i];
            end
            lo_sum_in = '0;
            hi_sum_in = '0;
         end
      end
   endgenerate

   assign trimmed = total_ff - lo_sum_ff - hi_sum_ff;
   assign kept    = n_ff - CNT_W'(tmsf_pkg::TRIM_FACTOR * TRIM);

   // Restoring divider, one quotient bit per cycle.
   assign shifted = {rem_ff, quo_ff[SUM_W-1]};
   assign ge      = (shifted >= {1'b0, div_ff});
   assign rem_in  = ge ? CNT_W'(shifted - {1'b0, div_ff}) : shifted[CNT_W-1:0];
   assign quo_in  = {quo_ff[SUM_W-2:0], ge};
   assign status.div_last = (step_ff == STEP_W'(SUM_W - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         wcnt_ff   <= tmsf_pkg::WCNT_RESET;
         fill_ff   <= '0;
         total_ff  <= '0;
         lo_sum_ff <= LO_SUM_INIT;
         hi_sum_ff <= '0;
         for (int i = 0; i < LIST_N; i++) begin
            lo_ff[i] <= '1;
            hi_ff[i] <= '0;
         end
      end else begin
         if (csr_write) begin
            wcnt_ff <= csr_window_count;
         end
         if (cmd.accept) begin
            fill_ff   <= fill_in;
            total_ff  <= total_ff + SUM_W'(req_sample);
            lo_sum_ff <= lo_sum_in;
            hi_sum_ff <= hi_sum_in;
            for (int i = 0; i < LIST_N; i++) begin
               lo_ff[i] <= lo_in[i];
               hi_ff[i] <= hi_in[i];
            end
         end else if (cmd.load) begin
            total_ff  <= '0;
            lo_sum_ff <= LO_SUM_INIT;
            hi_sum_ff <= '0;
            for (int i = 0; i < LIST_N; i++) begin
               lo_ff[i] <= '1;
               hi_ff[i] <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         n_ff    <= n_now;
         chan_ff <= req_channel;
      end
      if (cmd.load) begin
         quo_ff  <= trimmed;
         rem_ff  <= '0;
         div_ff  <= kept;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff  <= quo_in;
         rem_ff  <= rem_in;
         step_ff <= step_ff + STEP_W'(1);
      end
      if (cmd.finish) begin
         avg_ff      <= quo_ff[SW-1:0];
         chan_out_ff <= chan_ff;
      end
   end

   assign rsp_average     = avg_ff;
   assign rsp_channel_out = chan_out_ff;

endmodule

// ===== sim/trimmed_mean_sample_filter_unit_tb.sv =====
module trimmed_mean_sample_filter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_WIN      = 64;
   localparam int TRIM_N       = 1;
   localparam int SAMPLE_MAX   = (1 << tmsf_pkg::SAMPLE_W) - 1;
   localparam int DUT_LATENCY  = 20;
   localparam int CYCLE_LIMIT  = 1000000;

   typedef struct {
      logic [tmsf_pkg::SAMPLE_W-1:0] average;
      logic [tmsf_pkg::CHAN_W-1:0]   channel;
   } mean_result_type;

   logic                          clock;
   logic                          reset            = 1'b1;
   logic                          csr_write        = 1'b0;
   logic [tmsf_pkg::WCNT_W-1:0]   csr_window_count = '0;
   logic                          req_valid        = 1'b0;
   logic                          req_stall;
   logic [tmsf_pkg::SAMPLE_W-1:0] req_sample       = '0;
   logic [tmsf_pkg::CHAN_W-1:0]   req_channel      = '0;
   logic                          rsp_valid;
   logic                          rsp_stall        = 1'b0;
   logic [tmsf_pkg::SAMPLE_W-1:0] rsp_average;
   logic [tmsf_pkg::CHAN_W-1:0]   rsp_channel_out;

   // Predictor state: samples of the open window and the window register.
   logic [tmsf_pkg::SAMPLE_W-1:0] window_samples[$];
   logic [tmsf_pkg::WCNT_W-1:0]   window_setting = tmsf_pkg::WCNT_RESET;
   mean_result_type               pending_means[$];

   int  fault_count = 0;
   int  cycle_count = 0;
   int  stall_left  = 0;
   bit  steady      = 1'b0;

   trimmed_mean_sample_filter_unit #(
      .MAX_WINDOW(MAX_WIN),
      .TRIM      (TRIM_N)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_window_count(csr_window_count),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_channel     (req_channel),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_average     (rsp_average),
      .rsp_channel_out (rsp_channel_out)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("trimmed_mean_sample_filter_unit: mismatch");
         $finish;
      end
   end

   // Result side back-pressure: short bursts of stall, about one cycle in ten.
   always @(posedge clock) begin
      if (reset || steady) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < 3) begin
         rsp_stall  <= 1'b1;
         stall_left <= int'($urandom_range(0, 5));
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      mean_result_type exp_mean;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_means.size() == 0) begin
            fault_count++;
            $display("%0t: unexpected result beat, average %0d channel %0d",
                     $time, rsp_average, rsp_channel_out);
         end else begin
            exp_mean = pending_means.pop_front();
            if (rsp_average !== exp_mean.average) begin
               fault_count++;
               $display("%0t: average expected %0d, actual %0d",
                        $time, exp_mean.average, rsp_average);
            end
            if (rsp_channel_out !== exp_mean.channel) begin
               fault_count++;
               $display("%0t: channel_out expected %0d, actual %0d",
                        $time, exp_mean.channel, rsp_channel_out);
            end
         end
      end
   end

   // Adds one accepted sample to the predicted window and, when the window
   // closes, queues the trimmed floor mean of everything held.
   function automatic void absorb_sample(input logic [tmsf_pkg::SAMPLE_W-1:0] value,
                                         input logic [tmsf_pkg::CHAN_W-1:0]   chan);
      int              span;
      int              held;
      int              i;
      int              j;
      int              key;
      int              total;
      int              ordered[MAX_WIN];
      mean_result_type mean;
      span = int'(window_setting);
      if (span < tmsf_pkg::TRIM_FACTOR * TRIM_N + 1) begin
         span = tmsf_pkg::TRIM_FACTOR * TRIM_N + 1;
      end
      if (span > MAX_WIN) span = MAX_WIN;
      if (window_samples.size() < MAX_WIN) window_samples.push_back(value);
      held = window_samples.size();
      if (held < span) return;
      for (i = 0; i < held; i++) begin
         key = int'(window_samples[i]);
         j = i;
         while (j > 0 && ordered[j-1] > key) begin
            ordered[j] = ordered[j-1];
            j--;
         end
         ordered[j] = key;
      end
      total = 0;
      for (i = TRIM_N; i < held - TRIM_N; i++) total += ordered[i];
      mean.average = tmsf_pkg::SAMPLE_W'(total / (held - tmsf_pkg::TRIM_FACTOR * TRIM_N));
      mean.channel = chan;
      pending_means.push_back(mean);
      window_samples.delete();
   endfunction

   function automatic logic [tmsf_pkg::SAMPLE_W-1:0] draw_sample();
      int pick;
      pick = int'($urandom_range(0, 9));
      case (pick)
         0: return '0;
         1: return tmsf_pkg::SAMPLE_W'(SAMPLE_MAX);
         2: return tmsf_pkg::SAMPLE_W'(2048 + $urandom_range(0, 15));
         3: return tmsf_pkg::SAMPLE_W'($urandom_range(0, 31));
         default: return tmsf_pkg::SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
      endcase
   endfunction

   // Holds valid high from the previous beat when no gap is taken, so valid
   // gets at most one update per edge.
   task automatic send_sample(input logic [tmsf_pkg::SAMPLE_W-1:0] value,
                              input logic [tmsf_pkg::CHAN_W-1:0]   chan);
      int gap;
      if (!steady && $urandom_range(0, 99) < 3) begin
         gap = int'($urandom_range(1, 6));
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_sample  <= value;
      req_channel <= chan;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      absorb_sample(value, chan);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_means.size() != 0) @(posedge clock);
      repeat (2 * DUT_LATENCY) @(posedge clock);
   endtask

   task automatic write_window(input logic [tmsf_pkg::WCNT_W-1:0] value);
      drain_results();
      csr_write        <= 1'b1;
      csr_window_count <= value;
      @(posedge clock);
      window_setting = value;
      csr_write <= 1'b0;
   endtask

   // The first window runs at the reset window size.
   task automatic test_default_window();
      int ramp[10] = '{0, 4095, 2048, 1, 4094, 1365, 2730, 100, 3000, 7};
      int i;
      for (i = 0; i < 10; i++) begin
         send_sample(tmsf_pkg::SAMPLE_W'(ramp[i]), tmsf_pkg::CHAN_W'(15 - i));
      end
   endtask

   // A zero setting clamps to the smallest window; full scale and zero samples.
   task automatic test_smallest_window();
      write_window('0);
      repeat (3) send_sample(tmsf_pkg::SAMPLE_W'(SAMPLE_MAX), 4'hF);
      repeat (3) send_sample('0, 4'h0);
   endtask

   // Lowering the size below the samples already held closes the window on
   // the next beat with every held sample included.
   task automatic test_window_shrink();
      write_window(10);
      send_sample(4000, 1);
      send_sample(12, 2);
      send_sample(900, 3);
      send_sample(3100, 4);
      send_sample(2500, 5);
      drain_results();
      write_window(2);
      send_sample(1700, 9);
   endtask

   task automatic test_random_windows();
      int                          phase;
      int                          beats;
      logic [tmsf_pkg::WCNT_W-1:0] setting;
      for (phase = 0; phase < 24; phase++) begin
         case (phase % 8)
            0: setting = '1;
            1: setting = 3;
            2: setting = '0;
            3: setting = tmsf_pkg::WCNT_W'(MAX_WIN);
            4: setting = tmsf_pkg::WCNT_W'(MAX_WIN + 1);
            5: setting = tmsf_pkg::WCNT_W'($urandom_range(3, 16));
            6: setting = tmsf_pkg::WCNT_W'($urandom_range(0, 127));
            default: setting = tmsf_pkg::WCNT_W'($urandom_range(1, 2));
         endcase
         write_window(setting);
         steady = (phase == 12 || phase == 13);
         beats = int'($urandom_range(30, 90));
         repeat (beats) begin
            send_sample(draw_sample(), tmsf_pkg::CHAN_W'($urandom_range(0, 15)));
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_window();
      test_smallest_window();
      test_window_shrink();
      test_random_windows();
      drain_results();
      if (fault_count == 0) begin
         $display("trimmed_mean_sample_filter_unit: match");
      end else begin
         $display("trimmed_mean_sample_filter_unit: mismatch");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/tmsf_pkg.sv
sv/tmsf_ctrl.sv
sv/tmsf_datapath.sv
sv/trimmed_mean_sample_filter_unit.sv
sim/trimmed_mean_sample_filter_unit_tb.sv
